// File: rtl/core/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types, sizes and codes of the vectorscope plot accumulator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  // scope store geometry
  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ENTRY_W     = 24;

  // arithmetic widths
  localparam int COEF_W  = 16;
  localparam int SCALE_W = 20;
  localparam int SIZE_W  = 10;
  localparam int LUMA_W  = 26;   // sum of three 8x16 products
  localparam int DIFF_W  = 27;   // signed color difference, 16 fraction bits
  localparam int PROD_W  = 48;   // difference times scale, 32 fraction bits
  localparam int POS_W   = 49;   // centered position before rounding
  localparam int FRAC_W  = 32;
  localparam int CMP_W   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUMA_RED   = 3'd0,
    REG_LUMA_GREEN = 3'd1,
    REG_LUMA_BLUE  = 3'd2,
    REG_RED_SCALE  = 3'd3,
    REG_BLUE_SCALE = 3'd4,
    REG_WIDTH      = 3'd5,
    REG_HEIGHT     = 3'd6,
    REG_ADD        = 3'd7
  } reg_idx_t;

  localparam logic [COEF_W-1:0]  RST_LUMA_RED   = 16'd13933;
  localparam logic [COEF_W-1:0]  RST_LUMA_GREEN = 16'd46871;
  localparam logic [COEF_W-1:0]  RST_LUMA_BLUE  = 16'd4732;
  localparam logic [SCALE_W-1:0] RST_RED_SCALE  = 20'd24230;
  localparam logic [SCALE_W-1:0] RST_BLUE_SCALE = 20'd20566;
  localparam logic [SIZE_W-1:0]  RST_WIDTH      = 10'd256;
  localparam logic [SIZE_W-1:0]  RST_HEIGHT     = 10'd256;
  localparam logic [7:0]         RST_ADD        = 8'd9;

  // command codes
  localparam logic [1:0] CMD_PLOT  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [8:0] read_col;
    logic [8:0] read_row;
  } vpa_in_t;

  typedef struct packed {
    logic       plotted;
    logic [8:0] point_col;
    logic [8:0] point_row;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [7:0] entry_alpha;
  } vpa_out_t;

endpackage

// File: rtl/core/vpa_ram.sv
// ----------------------------------------------------------------------------
// vpa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vpa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/vectorscope_plot_accumulator.sv
// ----------------------------------------------------------------------------
// vectorscope_plot_accumulator
// Maps RGB pixels onto a vectorscope and accumulates hits in a scope store.
// ----------------------------------------------------------------------------
// After reset the block clears its scope store, one entry per cycle, across all
// MAX_WIDTH*MAX_HEIGHT entries (262144 at the default size); cmd_ready stays low
// during that pass while configuration writes are taken as usual. The block
// then works on one word at a time: a plot word goes through three arithmetic
// stages, placement, bounds check, a registered store read and write back before
// the next accept; a read or read-and-clear word starts at the bounds check. The
// finished result sits in an output register, so the next word is accepted
// while the result waits for res_ready; the sequencer only stalls at write
// back when the output register is still full.
// ----------------------------------------------------------------------------
module vectorscope_plot_accumulator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  vpa_pkg::vpa_in_t                  cmd_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output vpa_pkg::vpa_out_t                 res_data,
  input  logic                              cfg_wen,
  input  logic [vpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int COL_W  = vpa_pkg::COL_W;
  localparam int ROW_W  = vpa_pkg::ROW_W;
  localparam int ADDR_W = vpa_pkg::ADDR_W;
  localparam int DIFF_W = vpa_pkg::DIFF_W;
  localparam int PROD_W = vpa_pkg::PROD_W;
  localparam int POS_W  = vpa_pkg::POS_W;
  localparam int FRAC_W = vpa_pkg::FRAC_W;
  localparam int CMP_W  = vpa_pkg::CMP_W;
  localparam int SIZE_W = vpa_pkg::SIZE_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PROD  = 9'b000000100,
    S_LUMA  = 9'b000001000,
    S_SCALE = 9'b000010000,
    S_PLACE = 9'b000100000,
    S_CHECK = 9'b001000000,
    S_FETCH = 9'b010000000,
    S_MERGE = 9'b100000000
  } state_t;

  // floor(x/255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [7:0] bump(input logic [7:0] cur, input logic [7:0] inc);
    logic [8:0] s;
    s = {1'b0, cur} + {1'b0, inc};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // configuration registers
  logic [vpa_pkg::COEF_W-1:0]  luma_red, luma_green, luma_blue;
  logic [vpa_pkg::SCALE_W-1:0] red_scale, blue_scale;
  logic [SIZE_W-1:0]           screen_width, screen_height;
  logic [7:0]                  add_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_red      <= vpa_pkg::RST_LUMA_RED;
      luma_green    <= vpa_pkg::RST_LUMA_GREEN;
      luma_blue     <= vpa_pkg::RST_LUMA_BLUE;
      red_scale     <= vpa_pkg::RST_RED_SCALE;
      blue_scale    <= vpa_pkg::RST_BLUE_SCALE;
      screen_width  <= vpa_pkg::RST_WIDTH;
      screen_height <= vpa_pkg::RST_HEIGHT;
      add_amount    <= vpa_pkg::RST_ADD;
    end else if (cfg_wen) begin
      unique case (vpa_pkg::reg_idx_t'(cfg_index))
        vpa_pkg::REG_LUMA_RED:   luma_red      <= cfg_data[15:0];
        vpa_pkg::REG_LUMA_GREEN: luma_green    <= cfg_data[15:0];
        vpa_pkg::REG_LUMA_BLUE:  luma_blue     <= cfg_data[15:0];
        vpa_pkg::REG_RED_SCALE:  red_scale     <= cfg_data;
        vpa_pkg::REG_BLUE_SCALE: blue_scale    <= cfg_data;
        vpa_pkg::REG_WIDTH:      screen_width  <= cfg_data[SIZE_W-1:0];
        vpa_pkg::REG_HEIGHT:     screen_height <= cfg_data[SIZE_W-1:0];
        vpa_pkg::REG_ADD:        add_amount    <= cfg_data[7:0];
      endcase
    end
  end

  // screen size clamped to the store
  logic [SIZE_W-1:0] width_eff, height_eff;
  assign width_eff  = (CMP_W'(screen_width) > CMP_W'(vpa_pkg::MAX_WIDTH)) ?
                      SIZE_W'(vpa_pkg::MAX_WIDTH) : screen_width;
  assign height_eff = (CMP_W'(screen_height) > CMP_W'(vpa_pkg::MAX_HEIGHT)) ?
                      SIZE_W'(vpa_pkg::MAX_HEIGHT) : screen_height;

  state_t state, state_next;

  vpa_pkg::vpa_in_t item;
  logic [23:0] prod_r, prod_g, prod_b;
  logic [15:0] amt_r, amt_g, amt_b;
  logic [7:0]  inc_r, inc_g, inc_b;
  logic signed [DIFF_W-1:0] red_diff, blue_diff;
  logic signed [PROD_W-1:0] mul_x, mul_y;
  logic signed [POS_W-1:0]  pos_x, pos_y;
  logic              hit;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] clr_addr;

  // store access
  logic                          ram_wen;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [vpa_pkg::ENTRY_W-1:0]   ram_wdata;
  logic                          ram_ren;
  logic [ADDR_W-1:0]             ram_raddr;
  logic [vpa_pkg::ENTRY_W-1:0]   ram_rdata;

  vpa_ram #(
    .WIDTH (vpa_pkg::ENTRY_W),
    .DEPTH (vpa_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wen),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_ren),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  logic cmd_fire, slot_free, merge_go;
  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign slot_free = !res_valid || res_ready;
  assign merge_go  = (state == S_MERGE) && slot_free;

  // luma and differences
  logic [vpa_pkg::LUMA_W-1:0] luma;
  assign luma = vpa_pkg::LUMA_W'(prod_r) + vpa_pkg::LUMA_W'(prod_g) +
                vpa_pkg::LUMA_W'(prod_b);

  localparam int SCALE_W_S = vpa_pkg::SCALE_W;
  logic signed [SCALE_W_S:0] red_scale_s, blue_scale_s;
  assign red_scale_s  = $signed({1'b0, red_scale});
  assign blue_scale_s = $signed({1'b0, blue_scale});

  // centre offset plus one half pixel, 32 fraction bits
  logic signed [POS_W-1:0] base_x, base_y;
  assign base_x = $signed(POS_W'({(SIZE_W + 1)'(width_eff) + 11'd1, 31'b0}));
  assign base_y = $signed(POS_W'({(SIZE_W + 1)'(height_eff) + 11'd1, 31'b0}));

  // bounds check: rounded position is below zero when the biased value is <= 0
  logic x_in, y_in;
  assign x_in = !pos_x[POS_W-1] && (pos_x != '0) &&
                (pos_x[POS_W-2:FRAC_W] < CMP_W'(width_eff));
  assign y_in = !pos_y[POS_W-1] && (pos_y != '0) &&
                (pos_y[POS_W-2:FRAC_W] < CMP_W'(height_eff));

  logic              hit_next;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;

  always_comb begin
    hit_next = 1'b0;
    col_next = '0;
    row_next = '0;
    unique case (item.command) inside
      vpa_pkg::CMD_PLOT: begin
        hit_next = x_in && y_in;
        col_next = COL_W'(pos_x[POS_W-2:FRAC_W]);
        row_next = ROW_W'(pos_y[POS_W-2:FRAC_W]);
      end
      vpa_pkg::CMD_READ, vpa_pkg::CMD_CLEAR: begin
        hit_next = (CMP_W'(item.read_col) < CMP_W'(vpa_pkg::MAX_WIDTH)) &&
                   (CMP_W'(item.read_row) < CMP_W'(vpa_pkg::MAX_HEIGHT));
        col_next = COL_W'(item.read_col);
        row_next = ROW_W'(item.read_row);
      end
      default: begin
        hit_next = 1'b0;
      end
    endcase
  end

  logic [ADDR_W-1:0] entry_addr;
  assign entry_addr = ADDR_W'(row) * ADDR_W'(vpa_pkg::MAX_WIDTH) + ADDR_W'(col);

  // merge of the stored entry
  logic [7:0] cur_r, cur_g, cur_b, new_r, new_g, new_b;
  assign cur_r = ram_rdata[23:16];
  assign cur_g = ram_rdata[15:8];
  assign cur_b = ram_rdata[7:0];
  assign new_r = bump(cur_r, inc_r);
  assign new_g = bump(cur_g, inc_g);
  assign new_b = bump(cur_b, inc_b);

  vpa_pkg::vpa_out_t result;
  logic              writes_back;
  logic [vpa_pkg::ENTRY_W-1:0] merge_data;

  always_comb begin
    result      = '0;
    writes_back = 1'b0;
    merge_data  = '0;
    if (hit) begin
      unique case (item.command) inside
        vpa_pkg::CMD_PLOT: begin
          result.plotted     = 1'b1;
          result.point_col   = 9'(col);
          result.point_row   = 9'(row);
          result.entry_red   = new_r;
          result.entry_green = new_g;
          result.entry_blue  = new_b;
          result.entry_alpha = max3(new_r, new_g, new_b);
          writes_back        = 1'b1;
          merge_data         = {new_r, new_g, new_b};
        end
        vpa_pkg::CMD_READ, vpa_pkg::CMD_CLEAR: begin
          result.entry_red   = cur_r;
          result.entry_green = cur_g;
          result.entry_blue  = cur_b;
          result.entry_alpha = max3(cur_r, cur_g, cur_b);
          writes_back        = (item.command == vpa_pkg::CMD_CLEAR);
        end
        default: begin
          writes_back = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    ram_ren   = (state == S_FETCH) && hit;
    ram_raddr = entry_addr;
    if (state == S_CLEAR) begin
      ram_wen   = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_wen   = merge_go && writes_back;
      ram_waddr = addr;
      ram_wdata = merge_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(vpa_pkg::STORE_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_fire) begin
          state_next = (cmd_data.command == vpa_pkg::CMD_PLOT) ? S_PROD : S_CHECK;
        end
      end
      S_PROD:  state_next = S_LUMA;
      S_LUMA:  state_next = S_SCALE;
      S_SCALE: state_next = S_PLACE;
      S_PLACE: state_next = S_CHECK;
      S_CHECK: state_next = S_FETCH;
      S_FETCH: state_next = S_MERGE;
      S_MERGE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (merge_go) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_fire) item <= cmd_data;
    if (state == S_PROD) begin
      prod_r <= {16'b0, item.pixel_red}   * {8'b0, luma_red};
      prod_g <= {16'b0, item.pixel_green} * {8'b0, luma_green};
      prod_b <= {16'b0, item.pixel_blue}  * {8'b0, luma_blue};
      amt_r  <= {8'b0, item.pixel_red}    * {8'b0, add_amount};
      amt_g  <= {8'b0, item.pixel_green}  * {8'b0, add_amount};
      amt_b  <= {8'b0, item.pixel_blue}   * {8'b0, add_amount};
    end
    if (state == S_LUMA) begin
      red_diff  <= $signed({3'b0, item.pixel_red, 16'b0})  - $signed({1'b0, luma});
      blue_diff <= $signed({3'b0, item.pixel_blue, 16'b0}) - $signed({1'b0, luma});
      inc_r     <= div255(amt_r);
      inc_g     <= div255(amt_g);
      inc_b     <= div255(amt_b);
    end
    if (state == S_SCALE) begin
      mul_x <= PROD_W'(red_diff)  * PROD_W'(red_scale_s);
      mul_y <= PROD_W'(blue_diff) * PROD_W'(blue_scale_s);
    end
    if (state == S_PLACE) begin
      pos_x <= base_x + POS_W'(mul_x);
      pos_y <= base_y - POS_W'(mul_y);   // B-Y axis points up
    end
    if (state == S_CHECK) begin
      hit <= hit_next;
      col <= col_next;
      row <= row_next;
    end
    if (state == S_FETCH) addr <= entry_addr;
    if (merge_go) res_data <= result;
  end

endmodule

// File: rtl/core/vpa_checker.sv
// ----------------------------------------------------------------------------
// vpa_checker
// Port-level checks of the vectorscope plot accumulator, bound to the top.
// ----------------------------------------------------------------------------
module vpa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cmd_valid,
  input logic                           cmd_ready,
  input vpa_pkg::vpa_in_t               cmd_data,
  input logic                           res_valid,
  input logic                           res_ready,
  input vpa_pkg::vpa_out_t              res_data,
  input logic                           cfg_wen,
  input logic [vpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [vpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  // store clear runs after reset, so no word is taken right away
  a_no_accept_after_reset: assert property (@(posedge clk)
    rst |=> !cmd_ready)
    else $error("word accepted during store clear");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result shown right after reset");

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("second word accepted while one is in flight");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed");

endmodule

bind vectorscope_plot_accumulator vpa_checker u_vpa_checker (.*);

// File: tb/vectorscope_plot_accumulator_test.sv
// ----------------------------------------------------------------------------
// vectorscope_plot_accumulator_test
// Drives plot, read and read-and-clear words into the vectorscope accumulator
// under several register settings, mirrors the scope store, and checks every
// result word field by field against the mirrored prediction.
// ----------------------------------------------------------------------------
module vectorscope_plot_accumulator_test;

  localparam int COEF_W      = vpa_pkg::COEF_W;
  localparam int SCALE_W     = vpa_pkg::SCALE_W;
  localparam int SIZE_W      = vpa_pkg::SIZE_W;
  localparam int CFG_IDX_W   = vpa_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = vpa_pkg::CFG_DATA_W;
  localparam int MAX_WIDTH   = vpa_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT  = vpa_pkg::MAX_HEIGHT;
  localparam int STORE_DEPTH = vpa_pkg::STORE_DEPTH;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint HALF_Q32 = 64'sd2147483648;

  typedef struct {
    logic [COEF_W-1:0]  luma_red;
    logic [COEF_W-1:0]  luma_green;
    logic [COEF_W-1:0]  luma_blue;
    logic [SCALE_W-1:0] red_scale;
    logic [SCALE_W-1:0] blue_scale;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [7:0]         add;
  } scope_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_ready;
  vpa_pkg::vpa_in_t      cmd_data = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  vpa_pkg::vpa_out_t     res_data;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scope_cfg_t         scope_cfg;
  bit [23:0]          scope_mirror [STORE_DEPTH];
  logic [17:0]        lit_points [$];   // {row, col} of recent hits
  vpa_pkg::vpa_out_t  awaited_words [$];
  vpa_pkg::vpa_out_t  want;
  logic [23:0]        palette [8];
  int                 errors = 0;
  int                 cycle_count = 0;
  int                 quiet_send = 0;
  bit                 burst_hold = 1'b0;
  int                 stall_left = 0;
  int                 quiet_recv = 0;
  int unsigned        recv_roll;

  vectorscope_plot_accumulator dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint round_half_away(longint v);
    if (v >= 0) return (v + HALF_Q32) >>> 32;
    return -((-v + HALF_Q32) >>> 32);
  endfunction

  function automatic logic [7:0] add_sat(logic [7:0] cur, logic [7:0] c);
    int s;
    s = int'(cur) + (int'(c) * int'(scope_cfg.add)) / 255;
    return (s > 255) ? 8'd255 : 8'(s);
  endfunction

  function automatic void fill_entry(ref vpa_pkg::vpa_out_t res, input logic [23:0] e);
    logic [7:0] m;
    res.entry_red   = e[23:16];
    res.entry_green = e[15:8];
    res.entry_blue  = e[7:0];
    m = (e[23:16] > e[15:8]) ? e[23:16] : e[15:8];
    res.entry_alpha = (m > e[7:0]) ? m : e[7:0];
  endfunction

  function automatic vpa_pkg::vpa_out_t scope_outcome(vpa_pkg::vpa_in_t w);
    vpa_pkg::vpa_out_t res;
    longint r, g, b, luma, red_off, blue_off, wd, ht, px, py;
    int idx;
    logic [23:0] cur, upd;
    res = '0;
    case (w.command)
      vpa_pkg::CMD_PLOT: begin
        r = w.pixel_red;
        g = w.pixel_green;
        b = w.pixel_blue;
        wd = (scope_cfg.width > MAX_WIDTH) ? MAX_WIDTH : scope_cfg.width;
        ht = (scope_cfg.height > MAX_HEIGHT) ? MAX_HEIGHT : scope_cfg.height;
        luma = r * longint'(scope_cfg.luma_red) + g * longint'(scope_cfg.luma_green)
             + b * longint'(scope_cfg.luma_blue);
        red_off  = r * 65536 - luma;
        blue_off = b * 65536 - luma;
        // B-Y axis points up, so it is subtracted from the row centre
        px = round_half_away(wd * HALF_Q32 + red_off * longint'(scope_cfg.red_scale));
        py = round_half_away(ht * HALF_Q32 - blue_off * longint'(scope_cfg.blue_scale));
        if (px >= 0 && px < wd && py >= 0 && py < ht) begin
          idx = int'(py) * MAX_WIDTH + int'(px);
          cur = scope_mirror[idx];
          upd = {add_sat(cur[23:16], w.pixel_red), add_sat(cur[15:8], w.pixel_green),
                 add_sat(cur[7:0], w.pixel_blue)};
          scope_mirror[idx] = upd;
          res.plotted = 1'b1;
          res.point_col = 9'(px);
          res.point_row = 9'(py);
          fill_entry(res, upd);
          lit_points.push_back({9'(py), 9'(px)});
          if (lit_points.size() > 64) void'(lit_points.pop_front());
        end
      end
      vpa_pkg::CMD_READ, vpa_pkg::CMD_CLEAR: begin
        idx = int'(w.read_row) * MAX_WIDTH + int'(w.read_col);
        fill_entry(res, scope_mirror[idx]);
        if (w.command == vpa_pkg::CMD_CLEAR) scope_mirror[idx] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (cmd_valid && cmd_ready === 1'b1) awaited_words.push_back(scope_outcome(cmd_data));
  end

  // ---------------------------------------------------------------- checker

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (res_valid === 1'b1 && res_ready) begin
      if (awaited_words.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
      end else begin
        want = awaited_words.pop_front();
        check_field("plotted", want.plotted, res_data.plotted);
        check_field("point_col", want.point_col, res_data.point_col);
        check_field("point_row", want.point_row, res_data.point_row);
        check_field("entry_red", want.entry_red, res_data.entry_red);
        check_field("entry_green", want.entry_green, res_data.entry_green);
        check_field("entry_blue", want.entry_blue, res_data.entry_blue);
        check_field("entry_alpha", want.entry_alpha, res_data.entry_alpha);
      end
    end
  end

  // result side back-pressure: mostly short stalls, a few long, some calm runs
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_ready <= 1'b1;
      recv_roll = $urandom_range(0, 99);
      if (quiet_recv != 0) quiet_recv <= quiet_recv - 1;
      else if (recv_roll < 2) quiet_recv <= $urandom_range(30, 150);
      else if (recv_roll < 5) stall_left <= $urandom_range(10, 40);
      else if (recv_roll < 25) stall_left <= $urandom_range(1, 3);
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_hold) return 0;
    if (quiet_send > 0) begin
      quiet_send--;
      return 0;
    end
    if (roll < 2) begin
      quiet_send = $urandom_range(30, 150);
      return 0;
    end
    if (roll < 5) return $urandom_range(10, 40);
    if (roll < 35) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_word(vpa_pkg::vpa_in_t w);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data <= w;
    @(posedge clk);
    while (cmd_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(vpa_pkg::reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(scope_cfg_t c);
    wait_idle();
    set_reg(vpa_pkg::REG_LUMA_RED, CFG_DATA_W'(c.luma_red));
    set_reg(vpa_pkg::REG_LUMA_GREEN, CFG_DATA_W'(c.luma_green));
    set_reg(vpa_pkg::REG_LUMA_BLUE, CFG_DATA_W'(c.luma_blue));
    set_reg(vpa_pkg::REG_RED_SCALE, c.red_scale);
    set_reg(vpa_pkg::REG_BLUE_SCALE, c.blue_scale);
    set_reg(vpa_pkg::REG_WIDTH, CFG_DATA_W'(c.width));
    set_reg(vpa_pkg::REG_HEIGHT, CFG_DATA_W'(c.height));
    set_reg(vpa_pkg::REG_ADD, CFG_DATA_W'(c.add));
    cfg_wen <= 1'b0;
    scope_cfg = c;
  endtask

  function automatic scope_cfg_t default_config();
    scope_cfg_t c;
    c.luma_red = vpa_pkg::RST_LUMA_RED;
    c.luma_green = vpa_pkg::RST_LUMA_GREEN;
    c.luma_blue = vpa_pkg::RST_LUMA_BLUE;
    c.red_scale = vpa_pkg::RST_RED_SCALE;
    c.blue_scale = vpa_pkg::RST_BLUE_SCALE;
    c.width = vpa_pkg::RST_WIDTH;
    c.height = vpa_pkg::RST_HEIGHT;
    c.add = vpa_pkg::RST_ADD;
    return c;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return SIZE_W'($urandom_range(16, 512));
    if (roll == 6) return SIZE_W'(512);
    if (roll == 7) return SIZE_W'(511);
    if (roll == 8) return SIZE_W'($urandom_range(0, 8));
    return SIZE_W'($urandom_range(513, 1023));
  endfunction

  function automatic scope_cfg_t random_config();
    scope_cfg_t c;
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      // weights that sum to one keep grays at the centre
      c.luma_red = COEF_W'($urandom_range(8000, 22000));
      c.luma_blue = COEF_W'($urandom_range(2000, 9000));
      c.luma_green = COEF_W'(65536 - int'(c.luma_red) - int'(c.luma_blue));
    end else begin
      c.luma_red = COEF_W'($urandom);
      c.luma_green = COEF_W'($urandom);
      c.luma_blue = COEF_W'($urandom);
    end
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      c.red_scale = SCALE_W'($urandom_range(8000, 60000));
      c.blue_scale = SCALE_W'($urandom_range(8000, 60000));
    end else if (roll == 7) begin
      c.red_scale = '0;
      c.blue_scale = SCALE_W'($urandom_range(0, 40000));
    end else if (roll == 8) begin
      c.red_scale = SCALE_W'($urandom);
      c.blue_scale = SCALE_W'($urandom);
    end else begin
      c.red_scale = SCALE_W'($urandom_range(60000, 300000));
      c.blue_scale = SCALE_W'($urandom_range(60000, 300000));
    end
    c.width = pick_size();
    c.height = pick_size();
    roll = $urandom_range(0, 9);
    c.add = (roll < 8) ? 8'($urandom_range(1, 255)) : ((roll == 8) ? 8'd0 : 8'd255);
    return c;
  endfunction

  function automatic vpa_pkg::vpa_in_t plot_word(logic [23:0] color);
    vpa_pkg::vpa_in_t w;
    w.command = vpa_pkg::CMD_PLOT;
    w.pixel_red = color[23:16];
    w.pixel_green = color[15:8];
    w.pixel_blue = color[7:0];
    w.read_col = 9'($urandom);
    w.read_row = 9'($urandom);
    return w;
  endfunction

  function automatic vpa_pkg::vpa_in_t read_word(logic [1:0] cmd, logic [8:0] col,
                                                 logic [8:0] row);
    vpa_pkg::vpa_in_t w;
    w.command = cmd;
    w.pixel_red = 8'($urandom);
    w.pixel_green = 8'($urandom);
    w.pixel_blue = 8'($urandom);
    w.read_col = col;
    w.read_row = row;
    return w;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_default_plots();
    send_word(plot_word(24'h000000));
    send_word(plot_word(24'hFFFFFF));
    send_word(plot_word(24'hFF0000));
    send_word(plot_word(24'h00FF00));
    send_word(plot_word(24'h0000FF));
    send_word(plot_word(24'hFFFFFF));
    send_word(read_word(vpa_pkg::CMD_READ, 9'd128, 9'd128));
    send_word(read_word(vpa_pkg::CMD_CLEAR, 9'd128, 9'd128));
    send_word(read_word(vpa_pkg::CMD_READ, 9'd128, 9'd128));
    send_word(read_word(CMD_UNUSED, 9'h1FF, 9'h1FF));
    send_word(read_word(vpa_pkg::CMD_READ, 9'h1FF, 9'h1FF));
  endtask

  task automatic test_size_extremes();
    scope_cfg_t c;
    c = default_config();
    c.width = '0;   // nothing fits
    apply_config(c);
    send_word(plot_word(24'h808080));
    c.width = 10'd1023;   // both clamp to the store size
    c.height = 10'd513;
    apply_config(c);
    send_word(plot_word(24'h808080));
    send_word(plot_word(24'hFF00FF));
    c.width = 10'd1;   // centre at a half pixel, rounds out of bounds
    c.height = 10'd1;
    apply_config(c);
    send_word(plot_word(24'h808080));
    c.width = 10'd2;
    c.height = 10'd2;
    apply_config(c);
    send_word(plot_word(24'h808080));
  endtask

  task automatic test_gain_extremes();
    scope_cfg_t c;
    c = default_config();
    c.red_scale = '1;
    c.blue_scale = '1;
    c.add = 8'd255;
    apply_config(c);
    send_word(plot_word(24'h000000));
    send_word(plot_word(24'hFFFFFF));
    send_word(plot_word(24'hC80A0A));
    c.luma_red = '1;   // weights well above one
    c.luma_green = '1;
    c.luma_blue = '1;
    apply_config(c);
    send_word(plot_word(24'hFFFFFF));
    c.luma_red = '0;
    c.luma_green = '0;
    c.luma_blue = '0;
    c.red_scale = '0;
    c.blue_scale = '0;
    c.add = 8'd0;
    apply_config(c);
    send_word(plot_word(24'h010203));
    send_word(read_word(vpa_pkg::CMD_CLEAR, 9'd128, 9'd128));
  endtask

  task automatic random_items(int count);
    int sent, kind, k;
    logic [23:0] color;
    logic [17:0] spot;
    logic [63:0] raw;
    vpa_pkg::vpa_in_t w;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        color = $urandom_range(0, 1) ? palette[$urandom_range(0, 7)] : 24'($urandom);
        send_word(plot_word(color));
        sent++;
      end else if (kind < 70) begin
        // repeated hits on one entry, back to back
        color = palette[$urandom_range(0, 7)];
        k = $urandom_range(2, 6);
        burst_hold = 1'b1;
        repeat (k) send_word(plot_word(color));
        burst_hold = 1'b0;
        sent += k;
      end else if (kind < 95) begin
        if (lit_points.size() > 0 && $urandom_range(0, 3) != 0)
          spot = lit_points[$urandom_range(0, lit_points.size() - 1)];
        else
          spot = 18'($urandom);
        send_word(read_word($urandom_range(0, 1) ? vpa_pkg::CMD_READ : vpa_pkg::CMD_CLEAR,
                            spot[8:0], spot[17:9]));
        sent++;
      end else begin
        raw = {$urandom, $urandom};
        w = raw[$bits(vpa_pkg::vpa_in_t)-1:0];
        w.command = CMD_UNUSED;
        send_word(w);
        sent++;
      end
    end
  endtask

  task automatic test_random_phases();
    logic [7:0] v;
    for (int phase = 0; phase < 5; phase++) begin
      apply_config(random_config());
      for (int i = 0; i < 8; i++) begin
        v = 8'($urandom);
        palette[i] = $urandom_range(0, 3) == 0 ? {v, v, v} : 24'($urandom);
      end
      random_items(100);
    end
  endtask

  initial begin
    scope_cfg = default_config();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_default_plots();
    test_size_extremes();
    test_gain_extremes();
    test_random_phases();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
